[hdl/upd_pkg.sv]
// Package for the URL percent decoder: escape-tracking phase type, result
// beat type, queue sizing constants and the hex nibble conversion.
// No dependencies.
`default_nettype none

package upd_pkg;

	// Escape tracking phase; the fourth code never arises and acts as idle.
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ESC   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	// One decoded beat as it sits in the result queue.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} beat_t;

	localparam logic [7:0] ESC_RESET = 8'h25;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Hex digit value; any byte that is not a hex digit keeps its raw value.
	function automatic logic [7:0] nibble_of(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		if (v inside {[8'h30:8'h39]}) begin
			r = v - 8'h30;
		end else if (v inside {[8'h61:8'h66]}) begin
			r = v - 8'h61 + 8'd10;
		end else if (v inside {[8'h41:8'h46]}) begin
			r = v - 8'h41 + 8'd10;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/url_percent_decoder_core.sv]
// Top level of the URL percent decoder: input stage, escape tracking and a
// four-entry result queue. Depends on upd_pkg.
`default_nettype none

// Streaming percent-escape decoder.
// Input channel: in_valid / in_stall carry data_byte and last_byte, one raw
// byte per beat. Output channel: out_valid / out_stall carry out_byte and
// out_last, one decoded byte per beat. A beat moves on a rising edge with
// valid high and stall low.
// The escape byte is set through escape_char_we / escape_char; write it only
// while no string is in flight. Reset sets it to the percent sign.
// An accepted byte is registered, decoded in the next cycle and pushed into
// a four-entry result queue whose head drives the output ports.
// Throughput is one byte per cycle while in_stall stays low. An escape and
// its first digit give no beat; an escape cut short by the end of the string
// gives two beats. in_stall rises only when the queue could not absorb a
// further two beats; it does not depend on in_valid.
// While the receiver stalls, the queue fills and then holds the input off;
// the offered beat stays unchanged. Reset empties the queue and the input
// stage and clears any pending escape.
module url_percent_decoder_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       escape_char_we,
	input  wire logic [7:0] escape_char,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	localparam int unsigned PW = upd_pkg::PTR_W;
	localparam int unsigned CW = upd_pkg::CNT_W;
	localparam int unsigned DEPTH = upd_pkg::QUEUE_DEPTH;

	logic [7:0]       esc_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	upd_pkg::phase_t  phase_q;
	upd_pkg::phase_t  phase_d;
	logic [7:0]       first_q;
	logic [7:0]       first_d;
	upd_pkg::beat_t   res0;
	upd_pkg::beat_t   res1;
	logic [1:0]       n_res;
	upd_pkg::beat_t   queue_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    n_push;
	logic             in_take;
	logic             out_take;

	// Escape byte register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= upd_pkg::ESC_RESET;
		end else if (escape_char_we) begin
			esc_q <= escape_char;
		end
	end

	// Input handshake: accept only while the queue can take two more beats
	// beyond what the byte in the input stage will push.
	assign n_push   = {{(CW-2){1'b0}}, n_res};
	assign in_stall = (count_q + n_push) > CW'(DEPTH - 2);
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Next phase and held byte for the byte in the input stage.
	always_comb begin
		phase_d = phase_q;
		first_d = first_q;
		if (valid_s1) begin
			case (phase_q)
				upd_pkg::PH_ESC: begin
					if (last_s1) begin
						phase_d = upd_pkg::PH_IDLE;
						first_d = 8'h00;
					end else begin
						phase_d = upd_pkg::PH_DIGIT;
						first_d = byte_s1;
					end
				end
				upd_pkg::PH_DIGIT: begin
					phase_d = upd_pkg::PH_IDLE;
					first_d = 8'h00;
				end
				default: begin
					if (byte_s1 == esc_q && !last_s1) begin
						phase_d = upd_pkg::PH_ESC;
						first_d = byte_s1;
					end else begin
						phase_d = upd_pkg::PH_IDLE;
						first_d = 8'h00;
					end
				end
			endcase
		end
	end

	// Result beats for the byte in the input stage.
	always_comb begin
		logic [7:0] hi;
		logic [7:0] lo;
		hi = upd_pkg::nibble_of(first_q);
		lo = upd_pkg::nibble_of(byte_s1);
		res0  = '{data: byte_s1, last: last_s1};
		res1  = '{data: byte_s1, last: 1'b1};
		n_res = 2'd0;
		if (valid_s1) begin
			case (phase_q)
				upd_pkg::PH_ESC: begin
					if (last_s1) begin
						res0  = '{data: first_q, last: 1'b0};
						n_res = 2'd2;
					end
				end
				upd_pkg::PH_DIGIT: begin
					res0  = '{data: {hi[3:0], 4'h0} | lo, last: last_s1};
					n_res = 2'd1;
				end
				default: begin
					if (!(byte_s1 == esc_q && !last_s1)) begin
						n_res = 2'd1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upd_pkg::PH_IDLE;
			first_q <= 8'h00;
		end else begin
			phase_q <= phase_d;
			first_q <= first_d;
		end
	end

	// Result queue storage: up to two beats written per cycle.
	always_ff @(posedge clk) begin
		if (n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (n_res == 2'd2) begin
			queue_q[wr_ptr_q + PW'(1)] <= res1;
		end
	end

	// Queue pointers and fill count.
	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(n_res);
			if (out_take) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + n_push - {{(CW-1){1'b0}}, out_take};
		end
	end

	// Output beat comes from the queue head.
	assign out_valid = (count_q != '0);
	assign out_byte  = queue_q[rd_ptr_q].data;
	assign out_last  = queue_q[rd_ptr_q].last;

`ifndef SYNTHESIS
	// The queue never holds more beats than it has entries.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue overfilled");

	// Pushing never overruns the queue.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(n_res != 2'd0) |-> ((count_q + n_push) <= CW'(DEPTH)))
		else $error("push into a full result queue");

	// An accepted byte reaches the decode stage on the next edge.
	a_take_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> valid_s1)
		else $error("accepted byte lost before decode");

	// The end of a string always closes any pending escape.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> (phase_q == upd_pkg::PH_IDLE))
		else $error("escape still pending after last byte");

	// Two beats come only from an escape cut short by the string end.
	a_two_beats: assert property (@(posedge clk) disable iff (!arst_n)
		(n_res == 2'd2) |-> (phase_q == upd_pkg::PH_ESC && last_s1))
		else $error("unexpected double beat");
`endif

endmodule

`default_nettype wire

[sim/upd_stream_checker.sv]
// Stream checker for the URL percent decoder: watches the configuration port and
// both beat channels, predicts each decoded beat and compares it with the output.
// Depends on upd_pkg for the phase and beat types and the reset escape byte.
module upd_stream_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       escape_char_we,
	input  wire logic [7:0] escape_char,
	input  wire logic       in_valid,
	input  wire logic       in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       last_byte,
	input  wire logic       out_valid,
	input  wire logic       out_stall,
	input  wire logic [7:0] out_byte,
	input  wire logic       out_last,
	output int              mismatches,
	output int              pending
);

	localparam int PRINT_LIMIT = 50;

	// Decoded beats still owed by the block, oldest first.
	upd_pkg::beat_t  decoded_q[$];
	upd_pkg::phase_t esc_phase;
	logic [7:0]      held_byte;
	logic [7:0]      escape_reg;
	int              error_count = 0;

	assign mismatches = error_count;

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	// Value of a hex digit; any other byte keeps its own value.
	function automatic logic [7:0] hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			return c - "0";
		end
		if (c >= "a" && c <= "f") begin
			return c - "a" + 8'd10;
		end
		if (c >= "A" && c <= "F") begin
			return c - "A" + 8'd10;
		end
		return c;
	endfunction

	task automatic queue_result(input logic [7:0] value, input logic is_last);
		upd_pkg::beat_t e;
		e.data = value;
		e.last = is_last;
		decoded_q = {decoded_q, e};
	endtask

	// Advances the escape tracking by one input beat and queues what it yields.
	task automatic predict_beat(input logic [7:0] b, input logic is_last);
		case (esc_phase)
			upd_pkg::PH_ESC: begin
				if (is_last) begin
					// The string ends one byte after the escape: both pass through.
					queue_result(held_byte, 1'b0);
					queue_result(b, 1'b1);
					esc_phase = upd_pkg::PH_IDLE;
					held_byte = '0;
				end else begin
					held_byte = b;
					esc_phase = upd_pkg::PH_DIGIT;
				end
			end
			upd_pkg::PH_DIGIT: begin
				queue_result((hex_value(held_byte) << 4) | hex_value(b), is_last);
				esc_phase = upd_pkg::PH_IDLE;
				held_byte = '0;
			end
			default: begin
				// An escape byte that ends the string is not held back.
				if (b == escape_reg && !is_last) begin
					held_byte = b;
					esc_phase = upd_pkg::PH_ESC;
				end else begin
					queue_result(b, is_last);
					esc_phase = upd_pkg::PH_IDLE;
					held_byte = '0;
				end
			end
		endcase
	endtask

	// Compares one output beat with the oldest expectation.
	task automatic check_beat();
		upd_pkg::beat_t want;
		if (decoded_q.size() == 0) begin
			report_mismatch($sformatf("out beat %02h last %0b arrived with nothing expected",
				out_byte, out_last));
		end else begin
			want = decoded_q.pop_front();
			if (out_byte !== want.data) begin
				report_mismatch($sformatf("out_byte is %02h, expected %02h", out_byte, want.data));
			end
			if (out_last !== want.last) begin
				report_mismatch($sformatf("out_last is %0b, expected %0b on byte %02h",
					out_last, want.last, want.data));
			end
		end
	endtask

	// Sample both channels and the escape register write at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decoded_q.delete();
			esc_phase = upd_pkg::PH_IDLE;
			held_byte = '0;
			escape_reg = upd_pkg::ESC_RESET;
			pending <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_beat(data_byte, last_byte);
			end
			if (escape_char_we) begin
				escape_reg = escape_char;
			end
			if (out_valid && !out_stall) begin
				check_beat();
			end
			pending <= decoded_q.size();
		end
	end

endmodule

[sim/url_percent_decoder_core_tb.sv]
// Testbench top for the URL percent decoder: clock, reset, byte stimulus,
// receiver stalls, a stall watchdog and the final verdict.
// Depends on upd_pkg, url_percent_decoder_core and upd_stream_checker.
module url_percent_decoder_core_tb;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int QUIET_LIMIT  = 3000;
	localparam int PHASE_BYTES  = 305;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       escape_char_we;
	logic [7:0] escape_char;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       out_last;

	int         mismatches;
	int         pending;
	int         quiet_cycles = 0;
	int         bytes_sent = 0;
	bit         no_gaps = 1'b0;
	bit         hold_req = 1'b0;
	logic [7:0] esc_now = upd_pkg::ESC_RESET;

	url_percent_decoder_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.escape_char_we (escape_char_we),
		.escape_char    (escape_char),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.out_last       (out_last)
	);

	upd_stream_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.escape_char_we (escape_char_we),
		.escape_char    (escape_char),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.out_last       (out_last),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	// Free-running clock, period 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// End the run when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one input beat after a random gap and waits until it is taken.
	task automatic send_beat(input logic [7:0] b, input logic is_last);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= is_last;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	// Stops offering beats until every expected result has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_escape(input logic [7:0] value);
		wait_drained();
		escape_char_we <= 1'b1;
		escape_char <= value;
		@(posedge clk);
		escape_char_we <= 1'b0;
		esc_now = value;
	endtask

	function automatic logic [7:0] random_hex_digit();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) begin
			return 8'("0" + r);
		end
		if (r < 16) begin
			return 8'("a" + r - 10);
		end
		return 8'("A" + r - 16);
	endfunction

	// One string of random length: mostly escapes with two hex digits, some
	// broken escapes, cut-short escapes near the end and raw bytes.
	task automatic send_random_string();
		int         len;
		int         digits_due;
		logic [7:0] c;
		len = $urandom_range(1, 12);
		digits_due = 0;
		for (int k = 0; k < len; k++) begin
			if (digits_due > 0) begin
				c = ($urandom_range(0, 6) != 0) ? random_hex_digit() : 8'($urandom);
				digits_due--;
			end else if ($urandom_range(0, 2) == 0) begin
				c = esc_now;
				digits_due = 2;
			end else begin
				c = 8'($urandom);
			end
			send_beat(c, k == len - 1);
		end
		// Switch between gapped and back-to-back stretches now and then.
		if ($urandom_range(0, 9) == 0) begin
			no_gaps = !no_gaps;
		end
	endtask

	// Receiver: random stalls per beat, plus one long hold-off on request.
	initial begin
		int stall_len;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			stall_len = no_gaps ? 0 : $urandom_range(0, 11);
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Sender: reset, directed strings, then random phases under several escape bytes.
	initial begin
		logic [7:0] phase_escape [6];
		int         goal;
		phase_escape[0] = 8'hFF;
		phase_escape[1] = upd_pkg::ESC_RESET;
		phase_escape[2] = 8'($urandom);
		phase_escape[3] = 8'h00;
		phase_escape[4] = 8'($urandom);
		phase_escape[5] = upd_pkg::ESC_RESET;
		escape_char_we <= 1'b0;
		escape_char <= upd_pkg::ESC_RESET;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		last_byte <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Escape completed on the last byte of the string.
		send_beat("%", 1'b0);
		send_beat("4", 1'b0);
		send_beat("1", 1'b1);
		// Extreme byte values as one-byte strings.
		send_beat(8'h00, 1'b1);
		send_beat(8'hFF, 1'b1);
		// Lower- and upper-case hex digits.
		send_beat("%", 1'b0);
		send_beat("f", 1'b0);
		send_beat("F", 1'b0);
		send_beat("x", 1'b1);
		// Non-hex bytes folded in raw, then a decimal escape.
		send_beat("%", 1'b0);
		send_beat("G", 1'b0);
		send_beat("z", 1'b0);
		send_beat("%", 1'b0);
		send_beat("0", 1'b0);
		send_beat("9", 1'b1);
		// Escape byte that ends its string.
		send_beat("%", 1'b1);
		// Escape followed by only one byte before the end.
		send_beat("%", 1'b0);
		send_beat("a", 1'b1);
		// Escape byte changed while an escape is pending.
		send_beat("%", 1'b0);
		write_escape(8'h00);
		send_beat("3", 1'b0);
		send_beat("0", 1'b1);
		send_beat(8'h00, 1'b0);
		send_beat("A", 1'b0);
		send_beat("b", 1'b1);

		// Random phases; the third one starts with a long receiver hold-off
		// while the sender keeps offering back-to-back beats.
		for (int p = 0; p < 6; p++) begin
			write_escape(phase_escape[p]);
			if (p == 2) begin
				no_gaps = 1'b1;
				hold_req = 1'b1;
			end
			goal = bytes_sent + PHASE_BYTES;
			while (bytes_sent < goal) begin
				send_random_string();
			end
		end

		wait_drained();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
